FILE: rtl/ima_adpcm_wav_block_decoder_macros.svh
// assertion macros used by the decoder checker
`ifndef IMA_ADPCM_WAV_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_WAV_BLOCK_DECODER_MACROS_SVH

// clocked assertion, off while reset is active
`define IMADEC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same, on the usual clk and rst_n names
`define IMADEC_ASSERT(label, prop, msg) \
    `IMADEC_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: rtl/imadec_pkg.sv
// types, constants and nibble decode function of the ima adpcm block decoder
`default_nettype none

package imadec_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BLOCK_BYTES_RESET = 13'd256;
    localparam int unsigned MIN_BLOCK_BYTES  = 16;
    localparam int unsigned MONO_HDR_BYTES   = 4;
    localparam int unsigned STEREO_HDR_BYTES = 8;

    localparam logic [6:0] STEP_POS_MAX = 7'd88;

    localparam logic signed [17:0] PRED_MIN = -18'sd32768;
    localparam logic signed [17:0] PRED_MAX = 18'sd32767;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [6:0]         step_pos;
        logic signed [15:0] pred;
    } chan_state_t;

    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_MONO,
        JOB_STEREO
    } job_kind_t;

    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] INDEX_ADJUST [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    // one nibble of one channel: new predictor and step position
    function automatic chan_state_t decode_nibble(input chan_state_t s, input logic [3:0] nib);
        chan_state_t      r;
        logic [6:0]       idx;
        logic [14:0]      step;
        logic signed [8:0] ni;
        logic [16:0]      diff;
        logic signed [17:0] p;
        idx  = (s.step_pos > STEP_POS_MAX) ? STEP_POS_MAX : s.step_pos;
        step = STEP_TABLE[idx];
        ni   = $signed({2'b00, idx}) + 9'(INDEX_ADJUST[nib[2:0]]);
        if (ni < 9'sd0)
        begin
            r.step_pos = 7'd0;
        end
        else if (ni > $signed({2'b00, STEP_POS_MAX}))
        begin
            r.step_pos = STEP_POS_MAX;
        end
        else
        begin
            r.step_pos = ni[6:0];
        end
        diff = 17'(step >> 3);
        if (nib[0])
        begin
            diff = diff + 17'(step >> 2);
        end
        if (nib[1])
        begin
            diff = diff + 17'(step >> 1);
        end
        if (nib[2])
        begin
            diff = diff + 17'(step);
        end
        p = 18'(s.pred);
        if (nib[3])
        begin
            p = p - $signed({1'b0, diff});
            if (p < PRED_MIN)
            begin
                p = PRED_MIN;
            end
        end
        else
        begin
            p = p + $signed({1'b0, diff});
            if (p > PRED_MAX)
            begin
                p = PRED_MAX;
            end
        end
        r.pred = p[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ima_adpcm_wav_block_decoder.sv
// blocked ima adpcm decoder, mono or stereo, one data-chunk byte per input word
//
// Takes the data chunk of a blocked IMA ADPCM stream one byte per input word and
// gives decoded 16-bit samples, one output word per cycle while a byte still has
// words to emit and the output does not stall. Header bytes give no output. A
// mono data byte gives two words (low nibble first, right sample zero). In stereo
// the eighth byte of each 8-byte group gives eight left/right words; a partial
// group at block end is dropped. last marks the final word of a byte. A header,
// mono or group-ending stereo byte is held in one job register (other stereo
// bytes wait in a group buffer) while a single decode stage (one step-table
// lookup and one add with clamp per channel) emits one word per cycle into the
// output register while the output does not stall. The input stalls while a job
// still has words to emit. restart marks the first header byte of a block.
// Write stereo_mode and block_bytes only while no word is in flight.
`default_nettype none

module ima_adpcm_wav_block_decoder
    import imadec_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_BYTES = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word
);

    localparam int unsigned POS_W = $clog2(MAX_BLOCK_BYTES);
    localparam int unsigned LEN_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned CMP_W = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;

    localparam logic [1:0] HDR_PRED_LO  = 2'd0;
    localparam logic [1:0] HDR_PRED_HI  = 2'd1;
    localparam logic [1:0] HDR_STEP     = 2'd2;
    localparam logic [1:0] HDR_RESERVED = 2'd3;

    logic                  stereo_mode_reg;
    logic [CFG_DATA_W-1:0] block_bytes_reg;
    logic [POS_W-1:0]      block_pos_reg;
    logic [POS_W-1:0]      block_pos_next;
    logic [7:0]            group_reg [0:6];
    chan_state_t           chan_reg  [0:1];
    chan_state_t           chan_next [0:1];

    logic                  job_valid_reg;
    logic                  job_valid_next;
    job_kind_t             job_kind_reg;
    job_kind_t             job_kind_next;
    logic [31:0]           job_left_reg;
    logic [31:0]           job_left_next;
    logic [31:0]           job_right_reg;
    logic [31:0]           job_right_next;
    logic [2:0]            job_cnt_reg;
    logic [2:0]            job_cnt_next;
    logic                  job_ch_reg;
    logic                  job_ch_next;
    logic [1:0]            job_off_reg;
    logic [1:0]            job_off_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_word_t             out_word_reg;
    out_word_t             out_word_next;

    logic [CMP_W-1:0]      bb_ext;
    logic [CMP_W-1:0]      len;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      pos_inc;
    logic                  accept;
    logic                  is_hdr;
    logic                  grp_full;
    logic                  group_write;
    logic                  job_load;
    logic                  out_load;
    logic                  frame_last;
    logic                  emit;
    logic                  job_done;
    chan_state_t           dec_left;
    chan_state_t           dec_right;
    logic [6:0]            hdr_step;

    // block position and byte classification
    always_comb
    begin
        bb_ext = CMP_W'(block_bytes_reg);
        if (bb_ext < CMP_W'(MIN_BLOCK_BYTES))
        begin
            len = CMP_W'(MIN_BLOCK_BYTES);
        end
        else if (bb_ext > CMP_W'(MAX_BLOCK_BYTES))
        begin
            len = CMP_W'(MAX_BLOCK_BYTES);
        end
        else
        begin
            len = bb_ext;
        end
        if (in_word.restart || (CMP_W'(block_pos_reg) >= len))
        begin
            pos_ext = '0;
        end
        else
        begin
            pos_ext = CMP_W'(block_pos_reg);
        end
        pos_inc = pos_ext + CMP_W'(1);
        block_pos_next = (pos_inc >= len) ? '0 : pos_inc[POS_W-1:0];
        if (stereo_mode_reg)
        begin
            is_hdr = pos_ext < CMP_W'(STEREO_HDR_BYTES);
        end
        else
        begin
            is_hdr = pos_ext < CMP_W'(MONO_HDR_BYTES);
        end
        grp_full    = pos_ext[2:0] == 3'd7;
        accept      = in_valid && !in_stall;
        group_write = accept && stereo_mode_reg && !is_hdr && !grp_full;
        job_load    = accept && (is_hdr || !stereo_mode_reg || grp_full);
    end

    // decode stage control
    always_comb
    begin
        out_load   = !out_valid_reg || !out_stall;
        frame_last = (job_kind_reg == JOB_MONO) ? (job_cnt_reg == 3'd1) : (job_cnt_reg == 3'd7);
        emit       = job_valid_reg && (job_kind_reg != JOB_HEADER) && out_load;
        job_done   = job_valid_reg && ((job_kind_reg == JOB_HEADER) || (out_load && frame_last));
        in_stall   = job_valid_reg && !job_done;
        dec_left   = decode_nibble(chan_reg[0], job_left_reg[3:0]);
        dec_right  = decode_nibble(chan_reg[1], job_right_reg[3:0]);
        if (job_left_reg[7])
        begin
            hdr_step = 7'd0;
        end
        else if (job_left_reg[6:0] > STEP_POS_MAX)
        begin
            hdr_step = STEP_POS_MAX;
        end
        else
        begin
            hdr_step = job_left_reg[6:0];
        end
    end

    // channel state update
    always_comb
    begin
        chan_next[0] = chan_reg[0];
        chan_next[1] = chan_reg[1];
        if (job_valid_reg && (job_kind_reg == JOB_HEADER))
        begin
            unique case (job_off_reg)
                HDR_PRED_LO:  chan_next[job_ch_reg].pred[7:0]  = job_left_reg[7:0];
                HDR_PRED_HI:  chan_next[job_ch_reg].pred[15:8] = job_left_reg[7:0];
                HDR_STEP:     chan_next[job_ch_reg].step_pos  = hdr_step;
                HDR_RESERVED: chan_next[job_ch_reg] = chan_reg[job_ch_reg];
            endcase
        end
        else if (emit)
        begin
            chan_next[0] = dec_left;
            if (job_kind_reg == JOB_STEREO)
            begin
                chan_next[1] = dec_right;
            end
        end
    end

    // job register and output register
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_kind_next  = job_kind_reg;
        job_left_next  = job_left_reg;
        job_right_next = job_right_reg;
        job_cnt_next   = job_cnt_reg;
        job_ch_next    = job_ch_reg;
        job_off_next   = job_off_reg;
        if (job_done)
        begin
            job_valid_next = 1'b0;
        end
        else if (emit)
        begin
            job_left_next  = job_left_reg >> 4;
            job_right_next = job_right_reg >> 4;
            job_cnt_next   = job_cnt_reg + 3'd1;
        end
        if (job_load)
        begin
            job_valid_next = 1'b1;
            job_cnt_next   = 3'd0;
            job_ch_next    = stereo_mode_reg && pos_ext[2];
            job_off_next   = pos_ext[1:0];
            job_right_next = {in_word.data_byte, group_reg[6], group_reg[5], group_reg[4]};
            if (is_hdr)
            begin
                job_kind_next = JOB_HEADER;
                job_left_next = {24'd0, in_word.data_byte};
            end
            else if (stereo_mode_reg)
            begin
                job_kind_next = JOB_STEREO;
                job_left_next = {group_reg[3], group_reg[2], group_reg[1], group_reg[0]};
            end
            else
            begin
                job_kind_next = JOB_MONO;
                job_left_next = {24'd0, in_word.data_byte};
            end
        end
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_word_next.sample_left  = dec_left.pred;
            out_word_next.sample_right = (job_kind_reg == JOB_STEREO) ? dec_right.pred : 16'sd0;
            out_word_next.last         = frame_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg <= 1'b0;
            block_bytes_reg <= BLOCK_BYTES_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_STEREO_MODE: stereo_mode_reg <= cfg_data[0];
                CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_pos_reg <= '0;
            chan_reg[0]   <= '0;
            chan_reg[1]   <= '0;
            job_valid_reg <= 1'b0;
            job_kind_reg  <= JOB_HEADER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                block_pos_reg <= block_pos_next;
            end
            chan_reg[0]   <= chan_next[0];
            chan_reg[1]   <= chan_next[1];
            job_valid_reg <= job_valid_next;
            job_kind_reg  <= job_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_left_reg  <= job_left_next;
        job_right_reg <= job_right_next;
        job_cnt_reg   <= job_cnt_next;
        job_ch_reg    <= job_ch_next;
        job_off_reg   <= job_off_next;
        out_word_reg  <= out_word_next;
        if (group_write)
        begin
            group_reg[pos_ext[2:0]] <= in_word.data_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

FILE: rtl/imadec_checker.sv
// port-level assertions of the ima adpcm block decoder and their bind
`default_nettype none

`include "ima_adpcm_wav_block_decoder_macros.svh"

module imadec_checker
    import imadec_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    // a stalled output word holds
    `IMADEC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "output word changed while stalled")

    // words of one byte follow without a gap
    `IMADEC_ASSERT(a_no_gap, out_valid && !out_stall && !out_word.last |=> out_valid, "gap inside the words of one byte")

    // a new output word needs an accepted byte, registered in the job and then the output register
    `IMADEC_ASSERT(a_out_cause, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "output word without an accepted byte")

endmodule

bind ima_adpcm_wav_block_decoder imadec_checker u_imadec_checker (.*);

`default_nettype wire
